// ----- hdl/wsu_pkg.sv -----
// Shared types, codes and helpers for the tour search unit.
`default_nettype none
package wsu_pkg;

	// Fixed widths that follow from the field widths of the ports.
	localparam int unsigned ADDR_W  = 8;
	localparam int unsigned TRIED_W = 8;
	localparam int unsigned MIDX_W  = 3;
	localparam int unsigned POS_W   = 7;

	// Input modes.
	localparam logic [1:0] MODE_START  = 2'd0;
	localparam logic [1:0] MODE_STEP   = 2'd1;
	localparam logic [1:0] MODE_CANCEL = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] CFG_ROWS  = 3'd0;
	localparam logic [2:0] CFG_COLS  = 3'd1;
	localparam logic [2:0] CFG_MOVES = 3'd2;
	localparam logic [2:0] CFG_ROFF  = 3'd3;
	localparam logic [2:0] CFG_COFF  = 3'd4;

	// Result events.
	typedef enum logic [2:0] {
		EV_STARTED     = 3'd0,
		EV_ADVANCE     = 3'd1,
		EV_BACKTRACK   = 3'd2,
		EV_SOLVED      = 3'd3,
		EV_UNSOLVABLE  = 3'd4,
		EV_CANCELLED   = 3'd5,
		EV_REJECTED    = 3'd6
	} ev_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_TOP,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_PUSH,
		ST_EMIT0,
		ST_EMIT1
	} st_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] start_row;
		logic [3:0] start_col;
	} in_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [3:0] row;
		logic [3:0] col;
		logic [6:0] move_number;
		logic       last;
	} res_t;

	// Clamped configuration as seen by the sequencer.
	typedef struct packed {
		logic [4:0]  rows;
		logic [4:0]  cols;
		logic [3:0]  moves;
		logic [31:0] roff;
		logic [31:0] coff;
	} cfg_t;

	typedef struct packed {
		logic [3:0]         r;
		logic [3:0]         c;
		logic [TRIED_W-1:0] tried;
	} entry_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [6:0]        wdata;
		logic [ADDR_W-1:0] raddr;
	} board_req_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		entry_t            wdata;
		logic [ADDR_W-1:0] raddr;
	} stack_req_t;

	// Signed move delta of move idx, sign extended to a position.
	function automatic logic signed [POS_W-1:0] delta(input logic [31:0] offs,
		input logic [MIDX_W-1:0] idx);
		logic [3:0] d;
		d = offs[4*idx +: 4];
		return $signed({{(POS_W-4){d[3]}}, d});
	endfunction

endpackage
`default_nettype wire

// ----- hdl/wsu_board_ram.sv -----
// Visit board memory: one write and one registered read per cycle.
`default_nettype none
module wsu_board_ram #(
	parameter int unsigned AW = 6
) (
	input  wire logic                clk,
	input  wire wsu_pkg::board_req_t req,
	output logic [6:0]               rdata
);

	logic [6:0] mem [2**AW];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[AW-1:0]] <= req.wdata;
		end
		rdata <= mem[req.raddr[AW-1:0]];
	end

endmodule
`default_nettype wire

// ----- hdl/wsu_stack_ram.sv -----
// Path stack memory: one write and one registered read per cycle.
`default_nettype none
module wsu_stack_ram #(
	parameter int unsigned AW = 6
) (
	input  wire logic                clk,
	input  wire wsu_pkg::stack_req_t req,
	output wsu_pkg::entry_t          rdata
);

	wsu_pkg::entry_t mem [2**AW];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[AW-1:0]] <= req.wdata;
		end
		rdata <= mem[req.raddr[AW-1:0]];
	end

endmodule
`default_nettype wire

// ----- hdl/wsu_ctrl.sv -----
// Search sequencer: board clear, move scan with Warnsdorff ordering, push and pop.
`default_nettype none
module wsu_ctrl #(
	parameter int unsigned MAX_ROWS  = 8,
	parameter int unsigned MAX_COLS  = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire wsu_pkg::in_t        in_data,
	output logic                     in_stall,
	input  wire wsu_pkg::cfg_t       cfg,
	input  wire logic                out_free,
	output logic                     res_push,
	output wsu_pkg::res_t            res,
	output wsu_pkg::board_req_t      board_req,
	input  wire logic [6:0]          board_rdata,
	output wsu_pkg::stack_req_t      stack_req,
	input  wire wsu_pkg::entry_t     stack_rdata
);

	localparam int unsigned CELLS = MAX_ROWS * MAX_COLS;
	localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int unsigned DW    = $clog2(CELLS + 1);
	localparam int unsigned PW    = wsu_pkg::POS_W;

	wsu_pkg::st_t st_q, st_d;

	logic [DW-1:0] depth_q;
	logic          active_q;
	logic [AW-1:0] clr_q;

	logic [3:0]                  top_r_q, top_c_q;
	logic [wsu_pkg::TRIED_W-1:0] tried_q;
	logic [AW-1:0]               cell_q;

	logic [wsu_pkg::MIDX_W-1:0] mv_q;
	logic [3:0]                 k_q;

	logic                       v_s1, in_s1, first_s1, lastk_s1;
	logic [wsu_pkg::MIDX_W-1:0] mv_s1;
	logic [3:0]                 tr_s1, tc_s1;

	logic                       cand_ok_q, found_q;
	logic [3:0]                 cand_r_q, cand_c_q, best_r_q, best_c_q;
	logic [3:0]                 onw_q, best_q;
	logic [wsu_pkg::MIDX_W-1:0] best_idx_q;

	wsu_pkg::res_t res0_q, res1_q;
	wsu_pkg::res_t res_acc;
	logic          two_q;

	// Accept decode.
	logic acc, start_ok, step_go, solved, do_push, scan_end, free_s1;
	logic [DW+6:0] depth_ext;
	logic [6:0]    num;
	logic [9:0]    area;
	logic [11:0]   top_cell_full, scan_addr_full;

	assign acc       = in_valid && !in_stall;
	assign start_ok  = (in_data.start_row != 4'd0) && ({1'b0, in_data.start_row} <= cfg.rows)
		&& (in_data.start_col != 4'd0) && ({1'b0, in_data.start_col} <= cfg.cols);
	assign step_go   = (in_data.mode == wsu_pkg::MODE_STEP) && active_q
		&& (depth_q != '0);
	assign depth_ext = {7'd0, depth_q};
	assign num       = depth_ext[6:0];
	assign area      = 10'(cfg.rows) * 10'(cfg.cols);
	assign solved    = (10'(depth_q) == area);
	assign do_push   = found_q && (depth_q < DW'(CELLS));
	assign scan_end  = ({1'b0, mv_q} == cfg.moves - 4'd1) && (k_q == cfg.moves);
	assign free_s1   = in_s1 && (board_rdata == 7'd0);

	assign top_cell_full = 12'(stack_rdata.r) * 12'(MAX_COLS) + 12'(stack_rdata.c);

	// Result of an item that is answered without a search step.
	always_comb begin
		res_acc           = '0;
		res_acc.event_res = wsu_pkg::EV_REJECTED;
		res_acc.last      = 1'b1;
		unique case (in_data.mode)
			wsu_pkg::MODE_START: begin
				res_acc.row = in_data.start_row;
				res_acc.col = in_data.start_col;
				if (start_ok) res_acc.event_res = wsu_pkg::EV_STARTED;
			end
			wsu_pkg::MODE_CANCEL: begin
				if (active_q) res_acc.event_res = wsu_pkg::EV_CANCELLED;
			end
			wsu_pkg::MODE_STEP: begin
				if (active_q && depth_q == '0) res_acc.event_res = wsu_pkg::EV_UNSOLVABLE;
			end
			default: ;
		endcase
	end

	// Scan target: probe square of move mv_q, or its onward square of move k_q-1.
	logic signed [PW-1:0]       nr, nc, tr, tc;
	logic [wsu_pkg::MIDX_W-1:0] km1;
	logic                       in_range;

	always_comb begin
		km1 = wsu_pkg::MIDX_W'(k_q - 4'd1);
		nr  = $signed({3'd0, top_r_q}) + wsu_pkg::delta(cfg.roff, mv_q);
		nc  = $signed({3'd0, top_c_q}) + wsu_pkg::delta(cfg.coff, mv_q);
		tr  = nr;
		tc  = nc;
		if (k_q != 4'd0) begin
			tr = nr + wsu_pkg::delta(cfg.roff, km1);
			tc = nc + wsu_pkg::delta(cfg.coff, km1);
		end
		in_range = (tr >= 0) && (tr < $signed({2'd0, cfg.rows}))
			&& (tc >= 0) && (tc < $signed({2'd0, cfg.cols}));
		scan_addr_full = 12'(tr[3:0]) * 12'(MAX_COLS) + 12'(tc[3:0]);
	end

	// Next state.
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			wsu_pkg::ST_IDLE: begin
				if (acc) begin
					if (in_data.mode == wsu_pkg::MODE_START && start_ok) begin
						st_d = wsu_pkg::ST_CLEAR;
					end else if (step_go) begin
						st_d = wsu_pkg::ST_TOP;
					end else begin
						st_d = wsu_pkg::ST_EMIT0;
					end
				end
			end
			wsu_pkg::ST_CLEAR: begin
				if (clr_q == AW'(CELLS - 1)) st_d = wsu_pkg::ST_EMIT0;
			end
			wsu_pkg::ST_TOP: begin
				priority if (solved) st_d = wsu_pkg::ST_EMIT0;
				else if (cfg.moves == 4'd0) st_d = wsu_pkg::ST_DECIDE;
				else st_d = wsu_pkg::ST_SCAN;
			end
			wsu_pkg::ST_SCAN: begin
				if (scan_end) st_d = wsu_pkg::ST_DRAIN;
			end
			wsu_pkg::ST_DRAIN:  st_d = wsu_pkg::ST_DECIDE;
			wsu_pkg::ST_DECIDE: st_d = do_push ? wsu_pkg::ST_PUSH : wsu_pkg::ST_EMIT0;
			wsu_pkg::ST_PUSH:   st_d = wsu_pkg::ST_EMIT0;
			wsu_pkg::ST_EMIT0: begin
				if (out_free) st_d = two_q ? wsu_pkg::ST_EMIT1 : wsu_pkg::ST_IDLE;
			end
			wsu_pkg::ST_EMIT1: begin
				if (out_free) st_d = wsu_pkg::ST_IDLE;
			end
			default: st_d = wsu_pkg::ST_IDLE;
		endcase
	end

	// Outputs and memory requests.
	always_comb begin
		in_stall        = (st_q != wsu_pkg::ST_IDLE);
		res_push        = ((st_q == wsu_pkg::ST_EMIT0) || (st_q == wsu_pkg::ST_EMIT1))
			&& out_free;
		res             = (st_q == wsu_pkg::ST_EMIT1) ? res1_q : res0_q;
		board_req.we    = 1'b0;
		board_req.waddr = wsu_pkg::ADDR_W'(clr_q);
		board_req.wdata = 7'd0;
		board_req.raddr = scan_addr_full[wsu_pkg::ADDR_W-1:0];
		stack_req.we    = 1'b0;
		stack_req.waddr = '0;
		stack_req.wdata = '0;
		stack_req.raddr = wsu_pkg::ADDR_W'(depth_q - DW'(1));
		unique case (st_q)
			wsu_pkg::ST_IDLE: begin
				if (acc && in_data.mode == wsu_pkg::MODE_START && start_ok) begin
					stack_req.we      = 1'b1;
					stack_req.wdata.r = in_data.start_row - 4'd1;
					stack_req.wdata.c = in_data.start_col - 4'd1;
				end
			end
			wsu_pkg::ST_CLEAR: board_req.we = 1'b1;
			wsu_pkg::ST_TOP: begin
				board_req.we    = 1'b1;
				board_req.waddr = wsu_pkg::ADDR_W'(top_cell_full[AW-1:0]);
				board_req.wdata = num;
			end
			wsu_pkg::ST_DECIDE: begin
				if (do_push) begin
					stack_req.we          = 1'b1;
					stack_req.waddr       = wsu_pkg::ADDR_W'(depth_q - DW'(1));
					stack_req.wdata.r     = top_r_q;
					stack_req.wdata.c     = top_c_q;
					stack_req.wdata.tried = tried_q
						| (wsu_pkg::TRIED_W'(1) << best_idx_q);
				end else begin
					board_req.we    = 1'b1;
					board_req.waddr = wsu_pkg::ADDR_W'(cell_q);
				end
			end
			wsu_pkg::ST_PUSH: begin
				stack_req.we      = 1'b1;
				stack_req.waddr   = wsu_pkg::ADDR_W'(depth_q);
				stack_req.wdata.r = best_r_q;
				stack_req.wdata.c = best_c_q;
			end
			default: ;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= wsu_pkg::ST_IDLE;
			depth_q  <= '0;
			active_q <= 1'b0;
			two_q    <= 1'b0;
			v_s1     <= 1'b0;
		end else begin
			st_q <= st_d;
			v_s1 <= (st_q == wsu_pkg::ST_SCAN);
			if (st_q == wsu_pkg::ST_IDLE && acc) begin
				two_q <= 1'b0;
				unique case (in_data.mode)
					wsu_pkg::MODE_START: begin
						if (start_ok) begin
							depth_q  <= DW'(1);
							active_q <= 1'b1;
						end
					end
					wsu_pkg::MODE_CANCEL: active_q <= 1'b0;
					wsu_pkg::MODE_STEP: begin
						if (active_q && depth_q == '0) active_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (st_q == wsu_pkg::ST_TOP && solved) begin
				active_q <= 1'b0;
				two_q    <= 1'b1;
			end
			if (st_q == wsu_pkg::ST_DECIDE) begin
				two_q <= !do_push;
				if (!do_push) depth_q <= depth_q - DW'(1);
			end
			if (st_q == wsu_pkg::ST_PUSH) depth_q <= depth_q + DW'(1);
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (st_q == wsu_pkg::ST_IDLE && acc) begin
			clr_q  <= '0;
			res0_q <= res_acc;
		end
		if (st_q == wsu_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);

		// Latch the top entry and set up the scan.
		if (st_q == wsu_pkg::ST_TOP) begin
			top_r_q <= stack_rdata.r;
			top_c_q <= stack_rdata.c;
			tried_q <= stack_rdata.tried;
			cell_q  <= top_cell_full[AW-1:0];
			res0_q  <= '{event_res: wsu_pkg::EV_ADVANCE, row: stack_rdata.r + 4'd1,
				col: stack_rdata.c + 4'd1, move_number: num, last: 1'b0};
			res1_q  <= '{event_res: wsu_pkg::EV_SOLVED, row: stack_rdata.r + 4'd1,
				col: stack_rdata.c + 4'd1, move_number: num, last: 1'b1};
			mv_q    <= '0;
			k_q     <= '0;
			best_q  <= cfg.moves + 4'd1;
			found_q <= 1'b0;
		end

		// Issue one board read per cycle.
		if (st_q == wsu_pkg::ST_SCAN) begin
			in_s1    <= in_range;
			first_s1 <= (k_q == 4'd0);
			lastk_s1 <= (k_q == cfg.moves);
			mv_s1    <= mv_q;
			tr_s1    <= tr[3:0];
			tc_s1    <= tc[3:0];
			if (k_q == cfg.moves) begin
				k_q  <= '0;
				mv_q <= mv_q + wsu_pkg::MIDX_W'(1);
			end else begin
				k_q <= k_q + 4'd1;
			end
		end

		// Evaluate the read issued in the previous cycle.
		if (v_s1) begin
			if (first_s1) begin
				cand_ok_q <= free_s1 && !tried_q[mv_s1];
				cand_r_q  <= tr_s1;
				cand_c_q  <= tc_s1;
				onw_q     <= 4'd0;
			end else if (lastk_s1) begin
				if (cand_ok_q && (onw_q + 4'(free_s1)) < best_q) begin
					best_q     <= onw_q + 4'(free_s1);
					best_idx_q <= mv_s1;
					best_r_q   <= cand_r_q;
					best_c_q   <= cand_c_q;
					found_q    <= 1'b1;
				end
			end else begin
				onw_q <= onw_q + 4'(free_s1);
			end
		end

		// Push reports one advance; a dead end adds a backtrack.
		if (st_q == wsu_pkg::ST_DECIDE) begin
			if (do_push) begin
				res0_q.last <= 1'b1;
			end else begin
				res1_q.event_res <= wsu_pkg::EV_BACKTRACK;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/warnsdorff_tour_search_unit.sv -----
// Top level of the tour search unit: configuration, memories, sequencer, result register.
//
//  channel | signals                     | direction | beat
//  input   | in_valid, in_stall, in_data | in        | one start, step or cancel
//  output  | out_valid, out_stall, out_data | out    | one result event
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in | one register write
//
// A step reads the board once for every probe and onward square of the clamped
// moves, through the single read port of the board memory. A valid start first
// sweeps all MAX_ROWS*MAX_COLS board cells clear; an item that starts no search
// goes straight to its result. Reset idles the sequencer and resets the
// configuration; memories hold no reset. A stalled output holds the sequencer
// in its emit state; the next item is accepted once the last result of the
// current one sits in the output register.
`default_nettype none
module warnsdorff_tour_search_unit #(
	parameter int unsigned MAX_ROWS  = 8,
	parameter int unsigned MAX_COLS  = 8,
	parameter int unsigned MAX_MOVES = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire wsu_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output wsu_pkg::res_t      out_data,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [31:0]   cfg_data
);

	localparam int unsigned CELLS = MAX_ROWS * MAX_COLS;
	localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

	logic [3:0]  rows_q, cols_q, moves_q;
	logic [31:0] roff_q, coff_q;

	wsu_pkg::cfg_t       cfg;
	wsu_pkg::board_req_t board_req;
	wsu_pkg::stack_req_t stack_req;
	wsu_pkg::entry_t     stack_rdata;
	wsu_pkg::res_t       res;
	logic [6:0]          board_rdata;
	logic                res_push, out_free;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= 4'd8;
			cols_q  <= 4'd8;
			moves_q <= 4'd8;
			roff_q  <= '0;
			coff_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wsu_pkg::CFG_ROWS:  rows_q  <= cfg_data[3:0];
				wsu_pkg::CFG_COLS:  cols_q  <= cfg_data[3:0];
				wsu_pkg::CFG_MOVES: moves_q <= cfg_data[3:0];
				wsu_pkg::CFG_ROFF:  roff_q  <= cfg_data;
				wsu_pkg::CFG_COFF:  coff_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp to the built board and move table.
	always_comb begin
		cfg.rows  = ({1'b0, rows_q} > 5'(MAX_ROWS)) ? 5'(MAX_ROWS) : {1'b0, rows_q};
		cfg.cols  = ({1'b0, cols_q} > 5'(MAX_COLS)) ? 5'(MAX_COLS) : {1'b0, cols_q};
		cfg.moves = (moves_q > 4'(MAX_MOVES)) ? 4'(MAX_MOVES) : moves_q;
		cfg.roff  = roff_q;
		cfg.coff  = coff_q;
	end

	wsu_board_ram #(.AW(AW)) u_board (
		.clk   (clk),
		.req   (board_req),
		.rdata (board_rdata)
	);

	wsu_stack_ram #(.AW(AW)) u_stack (
		.clk   (clk),
		.req   (stack_req),
		.rdata (stack_rdata)
	);

	wsu_ctrl #(
		.MAX_ROWS  (MAX_ROWS),
		.MAX_COLS  (MAX_COLS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_data     (in_data),
		.in_stall    (in_stall),
		.cfg         (cfg),
		.out_free    (out_free),
		.res_push    (res_push),
		.res         (res),
		.board_req   (board_req),
		.board_rdata (board_rdata),
		.stack_req   (stack_req),
		.stack_rdata (stack_rdata)
	);

	// Output register.
	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= res_push;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) out_data <= res;
	end

endmodule
`default_nettype wire

// ----- hdl/wsu_checker.sv -----
// Port-level checks for the tour search unit and their binding.
`default_nettype none
module wsu_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_stall,
	input wire logic          out_valid,
	input wire logic          out_stall,
	input wire wsu_pkg::res_t out_data
);

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// An accepted item keeps the unit busy in the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("unit free right after accept");

	// Only defined events leave the unit.
	a_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.event_res <= wsu_pkg::EV_REJECTED)
		else $error("undefined event code");

	// While a result beat that is not last waits, the item is still in progress.
	a_more: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> in_stall)
		else $error("input taken before item finished");

endmodule

bind warnsdorff_tour_search_unit wsu_checker u_wsu_checker (.*);
`default_nettype wire
